>>> sv/bbcf_pkg.sv
// ----------------------------------------------------------------------------
// bbcf_pkg
// Shared types and constants of the bounding box batching core.
// ----------------------------------------------------------------------------
package bbcf_pkg;

   localparam int MAX_NETS     = 256;
   localparam int COORD_BITS   = 10;
   localparam int NET_BITS     = $clog2(MAX_NETS);
   localparam int NET_CNT_BITS = $clog2(MAX_NETS + 1);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic                  last;
      logic [7:0]            query_pos;
   } req_type;

   typedef struct packed {
      logic [7:0] net_index;
      logic [7:0] batch;
      logic [8:0] batch_count;
      logic       out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] lx;
      logic [COORD_BITS-1:0] ly;
      logic [COORD_BITS-1:0] ux;
      logic [COORD_BITS-1:0] uy;
   } box_type;

endpackage

>>> sv/bbox_conflict_free_batching_core.sv
// ----------------------------------------------------------------------------
// bbox_conflict_free_batching_core
// Loads net bounding boxes, sorts them by area and groups them into batches
// of mutually disjoint boxes; answers reads by sorted position.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | direction | moves
//  --------+-------------------------------+-----------+---------------------
//  request | req_valid req_stall req_payload | in      | load box / read
//  result  | rsp_valid rsp_stall rsp_payload | out     | one per read request
//
// A read request goes through the memory read of the sorted order and
// batch stores, then the result is formed in the output register. A load
// with last set starts an insertion sort by area and then the batching
// passes over the unplaced nets; each store has a single read port.
// Reset is synchronous and clears control state only; the stores need none.
// A read request is held off while an earlier result still waits.
// ----------------------------------------------------------------------------
module bbox_conflict_free_batching_core
   import bbcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int AREA_BITS = 2 * (COORD_BITS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RD,
      S_SORT_I, S_SORT_A, S_SORT_J, S_SORT_O, S_SORT_B, S_SORT_C,
      S_CLR,
      S_P_I, S_P_CHK, S_P_O, S_P_B,
      S_Q_J, S_Q_CHK, S_Q_O, S_Q_B
   } state_type;

   function automatic logic [AREA_BITS-1:0] box_area(input box_type b);
      logic [COORD_BITS:0] w;
      logic [COORD_BITS:0] h;
      w = {1'b0, b.ux} - {1'b0, b.lx} + 1'b1;
      h = {1'b0, b.uy} - {1'b0, b.ly} + 1'b1;
      return w * h;
   endfunction

   function automatic logic boxes_meet(input box_type a, input box_type b);
      return (a.lx <= b.ux) && (b.lx <= a.ux) && (a.ly <= b.uy) && (b.ly <= a.uy);
   endfunction

   state_type              state_ff, state_in;
   logic                   set_done_ff, set_done_in;
   logic [NET_CNT_BITS-1:0] net_count_ff, net_count_in;
   logic [NET_CNT_BITS-1:0] pass_count_ff, pass_count_in;
   logic [NET_CNT_BITS-1:0] i_ff, i_in;
   logic [NET_CNT_BITS-1:0] j_ff, j_in;
   logic [NET_CNT_BITS-1:0] left_ff, left_in;
   logic [NET_CNT_BITS-1:0] pass_ff, pass_in;
   logic [AREA_BITS-1:0]   area_a_ff, area_a_in;
   logic [AREA_BITS-1:0]   area_b_ff, area_b_in;
   logic [NET_BITS-1:0]    tmp_ff, tmp_in;
   box_type                cur_ff, cur_in;
   logic [7:0]             q_ff, q_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   box_wen, ord_wen, pn_wen;
   logic [NET_BITS-1:0]    box_waddr, box_raddr, ord_waddr, ord_raddr, pn_waddr, pn_raddr;
   box_type                box_wdata, box_rdata;
   logic [NET_BITS-1:0]    ord_wdata, ord_rdata;
   logic [NET_BITS:0]      pn_wdata, pn_rdata;

   logic                   accept;
   logic [NET_CNT_BITS-1:0] cnt;

   bbcf_ram #(.WIDTH(4 * COORD_BITS), .DEPTH(MAX_NETS)) u_box_ram (
      .clock(clock), .wen(box_wen), .waddr(box_waddr), .wdata(box_wdata),
      .raddr(box_raddr), .rdata(box_rdata)
   );

   bbcf_ram #(.WIDTH(NET_BITS), .DEPTH(MAX_NETS)) u_ord_ram (
      .clock(clock), .wen(ord_wen), .waddr(ord_waddr), .wdata(ord_wdata),
      .raddr(ord_raddr), .rdata(ord_rdata)
   );

   // batch store entry: {placed, pass}
   bbcf_ram #(.WIDTH(NET_BITS + 1), .DEPTH(MAX_NETS)) u_pn_ram (
      .clock(clock), .wen(pn_wen), .waddr(pn_waddr), .wdata(pn_wdata),
      .raddr(pn_raddr), .rdata(pn_rdata)
   );

   // Requests wait outside idle; reads also wait while a result is pending.
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && (req_payload.cmd == CMD_READ));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      set_done_in   = set_done_ff;
      net_count_in  = net_count_ff;
      pass_count_in = pass_count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      left_in       = left_ff;
      pass_in       = pass_ff;
      area_a_in     = area_a_ff;
      area_b_in     = area_b_ff;
      tmp_in        = tmp_ff;
      cur_in        = cur_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      box_wen   = 1'b0;
      box_waddr = '0;
      box_wdata = '0;
      box_raddr = '0;
      ord_wen   = 1'b0;
      ord_waddr = '0;
      ord_wdata = '0;
      ord_raddr = '0;
      pn_wen    = 1'b0;
      pn_waddr  = '0;
      pn_wdata  = '0;
      pn_raddr  = '0;
      cnt       = set_done_ff ? '0 : net_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_payload.cmd == CMD_LOAD) begin
                  // a load after batching starts a new set
                  if (set_done_ff) begin
                     set_done_in   = 1'b0;
                     pass_count_in = '0;
                  end
                  net_count_in = cnt;
                  if (cnt < NET_CNT_BITS'(MAX_NETS)) begin
                     box_wen   = 1'b1;
                     box_waddr = cnt[NET_BITS-1:0];
                     // normalize corners: each axis min to max
                     box_wdata.lx = (req_payload.start_x < req_payload.end_x) ?
                                    req_payload.start_x : req_payload.end_x;
                     box_wdata.ux = (req_payload.start_x < req_payload.end_x) ?
                                    req_payload.end_x : req_payload.start_x;
                     box_wdata.ly = (req_payload.start_y < req_payload.end_y) ?
                                    req_payload.start_y : req_payload.end_y;
                     box_wdata.uy = (req_payload.start_y < req_payload.end_y) ?
                                    req_payload.end_y : req_payload.start_y;
                     net_count_in = cnt + 1'b1;
                  end
                  if (req_payload.last) begin
                     i_in     = '0;
                     state_in = S_SORT_I;
                  end
               end else begin
                  q_in      = req_payload.query_pos;
                  ord_raddr = req_payload.query_pos[NET_BITS-1:0];
                  pn_raddr  = req_payload.query_pos[NET_BITS-1:0];
                  state_in  = S_RD;
               end
            end
         end

         S_RD: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (!set_done_ff) begin
               rsp_in.out_of_range = 1'b1;
            end else if ({1'b0, q_ff} >= net_count_ff) begin
               rsp_in.batch_count  = pass_count_ff;
               rsp_in.out_of_range = 1'b1;
            end else begin
               rsp_in.net_index   = ord_rdata;
               rsp_in.batch       = 8'(pass_count_ff - 1'b1 - {1'b0, pn_rdata[NET_BITS-1:0]});
               rsp_in.batch_count = pass_count_ff;
            end
            state_in = S_IDLE;
         end

         // insertion sort, largest area first, stable
         S_SORT_I: begin
            if (i_ff == net_count_ff) begin
               i_in     = '0;
               state_in = S_CLR;
            end else begin
               box_raddr = i_ff[NET_BITS-1:0];
               state_in  = S_SORT_A;
            end
         end

         S_SORT_A: begin
            area_a_in = box_area(box_rdata);
            j_in      = i_ff;
            state_in  = S_SORT_J;
         end

         S_SORT_J: begin
            if (j_ff == '0) begin
               ord_wen   = 1'b1;
               ord_waddr = '0;
               ord_wdata = i_ff[NET_BITS-1:0];
               i_in      = i_ff + 1'b1;
               state_in  = S_SORT_I;
            end else begin
               ord_raddr = NET_BITS'(j_ff - 1'b1);
               state_in  = S_SORT_O;
            end
         end

         S_SORT_O: begin
            tmp_in    = ord_rdata;
            box_raddr = ord_rdata;
            state_in  = S_SORT_B;
         end

         S_SORT_B: begin
            area_b_in = box_area(box_rdata);
            state_in  = S_SORT_C;
         end

         S_SORT_C: begin
            ord_wen   = 1'b1;
            ord_waddr = j_ff[NET_BITS-1:0];
            if (area_b_ff < area_a_ff) begin
               // shift the smaller entry up one slot
               ord_wdata = tmp_ff;
               j_in      = j_ff - 1'b1;
               state_in  = S_SORT_J;
            end else begin
               ord_wdata = i_ff[NET_BITS-1:0];
               i_in      = i_ff + 1'b1;
               state_in  = S_SORT_I;
            end
         end

         // mark every sorted slot unplaced
         S_CLR: begin
            if (i_ff == net_count_ff) begin
               i_in    = '0;
               left_in = net_count_ff;
               pass_in = '0;
               if (net_count_ff == '0) begin
                  pass_count_in = '0;
                  set_done_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_P_I;
               end
            end else begin
               pn_wen   = 1'b1;
               pn_waddr = i_ff[NET_BITS-1:0];
               pn_wdata = '0;
               i_in     = i_ff + 1'b1;
            end
         end

         S_P_I: begin
            if (i_ff == net_count_ff) begin
               pass_in = pass_ff + 1'b1;
               i_in    = '0;
               if (left_ff == '0) begin
                  pass_count_in = pass_ff + 1'b1;
                  set_done_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               pn_raddr = i_ff[NET_BITS-1:0];
               state_in = S_P_CHK;
            end
         end

         S_P_CHK: begin
            if (pn_rdata[NET_BITS]) begin
               i_in     = i_ff + 1'b1;
               state_in = S_P_I;
            end else begin
               ord_raddr = i_ff[NET_BITS-1:0];
               state_in  = S_P_O;
            end
         end

         S_P_O: begin
            box_raddr = ord_rdata;
            state_in  = S_P_B;
         end

         S_P_B: begin
            cur_in   = box_rdata;
            j_in     = '0;
            state_in = S_Q_J;
         end

         // scan earlier slots placed in this pass
         S_Q_J: begin
            if (j_ff == i_ff) begin
               pn_wen   = 1'b1;
               pn_waddr = i_ff[NET_BITS-1:0];
               pn_wdata = {1'b1, pass_ff[NET_BITS-1:0]};
               left_in  = left_ff - 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = S_P_I;
            end else begin
               pn_raddr = j_ff[NET_BITS-1:0];
               state_in = S_Q_CHK;
            end
         end

         S_Q_CHK: begin
            if (pn_rdata[NET_BITS] && (pn_rdata[NET_BITS-1:0] == pass_ff[NET_BITS-1:0])) begin
               ord_raddr = j_ff[NET_BITS-1:0];
               state_in  = S_Q_O;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_Q_J;
            end
         end

         S_Q_O: begin
            box_raddr = ord_rdata;
            state_in  = S_Q_B;
         end

         S_Q_B: begin
            if (boxes_meet(cur_ff, box_rdata)) begin
               // conflict: leave this net for a later pass
               i_in     = i_ff + 1'b1;
               state_in = S_P_I;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_Q_J;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         set_done_ff   <= 1'b0;
         net_count_ff  <= '0;
         pass_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         left_ff       <= '0;
         pass_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         set_done_ff   <= set_done_in;
         net_count_ff  <= net_count_in;
         pass_count_ff <= pass_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         left_ff       <= left_in;
         pass_ff       <= pass_in;
      end
      area_a_ff <= area_a_in;
      area_b_ff <= area_b_in;
      tmp_ff    <= tmp_in;
      cur_ff    <= cur_in;
      q_ff      <= q_in;
      rsp_ff    <= rsp_in;
   end

endmodule

>>> sv/bbcf_ram.sv
// ----------------------------------------------------------------------------
// bbcf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/bbcf_checker.sv
// ----------------------------------------------------------------------------
// bbcf_checker
// Port level checks of the bounding box batching core.
// ----------------------------------------------------------------------------
module bbcf_checker
   import bbcf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.cmd == CMD_READ) |-> ##2 rsp_valid)
      else $error("read request gave no result in two cycles");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_of_range |->
         (rsp_payload.net_index == '0) && (rsp_payload.batch == '0))
      else $error("out of range result carries data");

   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.out_of_range |->
         ({1'b0, rsp_payload.batch} < rsp_payload.batch_count))
      else $error("batch not below batch count");

endmodule

bind bbox_conflict_free_batching_core bbcf_checker u_bbcf_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);
